// ----- design/mtfs_pkg.sv -----
// Shared types and constants for the max-tree first-at-least search block.
package mtfs_pkg;

	localparam int VALUE_BITS = 32;
	localparam int INDEX_BITS = 10;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	localparam value_t INT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef struct packed {
		logic                  kind;
		logic [INDEX_BITS-1:0] index;
		value_t                value;
	} req_t;

	typedef struct packed {
		logic                  found;
		logic [INDEX_BITS-1:0] position;
		value_t                leaf_value;
	} rsp_t;

endpackage

// ----- design/mtfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mtfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/mtfs_cmp.sv -----
// Shared signed compare unit: greater-or-equal test and maximum of two values.
module mtfs_cmp (
	input  mtfs_pkg::value_t a,
	input  mtfs_pkg::value_t b,
	output logic             ge,
	output mtfs_pkg::value_t max
);

	import mtfs_pkg::*;

	assign ge  = (a >= b);
	assign max = ge ? a : b;

endmodule

// ----- design/max_tree_first_at_least_search.sv -----
// Top level: sequencer that walks the max-tree in RAM one level per cycle.
//
// The block holds a binary max-tree of 2*SPAN nodes in a single RAM, where
// SPAN is LEAVES rounded up to a power of two. After reset it runs a clearing
// pass that writes the most negative value to every node; busy stays high
// meanwhile. An item is taken when start is high and busy is low. An update
// does the leaf write, then one parent write per level, each using one RAM read
// of the sibling and the shared compare unit. An update whose index is not
// below LEAVES is dropped in the accept cycle. A query does the root read and
// check, one RAM read and compare per level on the way down, and a final read
// of the chosen leaf. Each query gives one result, shown on rsp for the single
// cycle that rsp_valid is high; the receiver cannot stall it. Updates give no
// result.
module max_tree_first_at_least_search #(
	parameter int LEAVES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mtfs_pkg::req_t  req,
	output logic            rsp_valid,
	output mtfs_pkg::rsp_t  rsp
);

	import mtfs_pkg::*;

	localparam int SPAN_LOG = $clog2(LEAVES);
	localparam int SPAN     = 1 << SPAN_LOG;
	localparam int NODE_W   = SPAN_LOG + 1;
	localparam int NODES    = 2 * SPAN;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_QROOT = 3'd3;
	localparam logic [2:0] ST_QWALK = 3'd4;
	localparam logic [2:0] ST_QLEAF = 3'd5;

	localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(1);

	logic [2:0]        state_q, state_d;
	logic [NODE_W-1:0] node_q, node_d;
	logic [NODE_W-1:0] clr_q;
	value_t            cur_q, cur_d;
	value_t            target_q;
	logic              rsp_valid_q, rsp_valid_d;
	rsp_t              rsp_q, rsp_d;

	logic              ram_we;
	logic [NODE_W-1:0] ram_waddr, ram_raddr;
	value_t            ram_wdata, ram_rdata;

	value_t            cmp_a, cmp_b, cmp_max;
	logic              cmp_ge;

	logic              accept;
	logic              in_range;
	logic [NODE_W-1:0] leaf_node;
	logic [NODE_W-1:0] parent;
	logic [NODE_W-1:0] next_node;

	mtfs_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(NODES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Updates take the max of the carried value and the sibling; queries
	// test the node just read against the target.
	mtfs_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.ge (cmp_ge),
		.max(cmp_max)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign in_range  = (32'(req.index) < 32'(LEAVES));
	assign leaf_node = NODE_W'(SPAN) + NODE_W'(req.index);
	assign parent    = node_q >> 1;
	assign next_node = cmp_ge ? node_q : (node_q | NODE_W'(1));

	always_comb begin
		cmp_a = ram_rdata;
		cmp_b = target_q;
		if (state_q == ST_UPD) begin
			cmp_a = cur_q;
			cmp_b = ram_rdata;
		end
	end

	always_comb begin
		state_d     = state_q;
		node_d      = node_q;
		cur_d       = cur_q;
		rsp_valid_d = 1'b0;
		rsp_d       = rsp_q;
		ram_we      = 1'b0;
		ram_waddr   = node_q;
		ram_wdata   = cur_q;
		ram_raddr   = node_q;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = INT_MIN;
				if (clr_q == NODE_W'(NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_QUERY) begin
						ram_raddr = NODE_ROOT;
						state_d   = ST_QROOT;
					end else if (in_range) begin
						ram_we    = 1'b1;
						ram_waddr = leaf_node;
						ram_wdata = req.value;
						ram_raddr = leaf_node ^ NODE_W'(1);
						node_d    = leaf_node;
						cur_d     = req.value;
						state_d   = ST_UPD;
					end
				end
			end
			ST_UPD: begin
				ram_we    = 1'b1;
				ram_waddr = parent;
				ram_wdata = cmp_max;
				ram_raddr = parent ^ NODE_W'(1);
				node_d    = parent;
				cur_d     = cmp_max;
				if (parent == NODE_ROOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_QROOT: begin
				if (!cmp_ge) begin
					rsp_valid_d      = 1'b1;
					rsp_d.found      = 1'b0;
					rsp_d.position   = '0;
					rsp_d.leaf_value = INT_MIN;
					state_d          = ST_IDLE;
				end else begin
					ram_raddr = NODE_W'(2);
					node_d    = NODE_W'(2);
					state_d   = ST_QWALK;
				end
			end
			ST_QWALK: begin
				// The top node bit marks a leaf; otherwise descend to the left child.
				if (next_node[NODE_W-1]) begin
					ram_raddr = next_node;
					node_d    = next_node;
					state_d   = ST_QLEAF;
				end else begin
					ram_raddr = next_node << 1;
					node_d    = next_node << 1;
				end
			end
			ST_QLEAF: begin
				rsp_valid_d      = 1'b1;
				rsp_d.found      = 1'b1;
				rsp_d.position   = INDEX_BITS'(node_q[SPAN_LOG-1:0]);
				rsp_d.leaf_value = ram_rdata;
				state_d          = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		cur_q  <= cur_d;
		rsp_q  <= rsp_d;
		if (accept) begin
			target_q <= req.value;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rsp_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ($past(state_q) == ST_QROOT || $past(state_q) == ST_QLEAF))
		else $error("result without a query finishing");

	a_not_found_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.found) |-> (rsp_q.position == '0 && rsp_q.leaf_value == INT_MIN))
		else $error("not-found result carries a position or value");

	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> !rsp_valid_q)
		else $error("update produced a result");

	a_leaf_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QLEAF) |-> node_q[NODE_W-1])
		else $error("query finished above the leaf level");

	// The walk always arrives on a left child, down to and including the leaf level.
	a_walk_left_child: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QWALK) |-> (!node_q[0] && node_q != '0))
		else $error("query walk is not on a left child");

endmodule
